/* sv/kmd_pkg.sv */
// Shared types and constants for the 2-D Manhattan k-means core.
// Used by kmd_div and kmeans_2d_manhattan_core; depends on nothing.
`default_nettype none
package kmd_pkg;

  localparam int COORD_W = 16;
  typedef logic signed [COORD_W-1:0] coord_t;

  // Configuration register indexes (word address bits).
  localparam logic [1:0] REG_CLUSTER_COUNT = 2'd0;
  localparam logic [1:0] REG_MOVE_THRESH   = 2'd1;
  localparam logic [1:0] REG_ITER_CAP      = 2'd2;

  localparam logic [4:0]  CLUSTER_COUNT_RST = 5'd2;
  localparam logic [31:0] MOVE_THRESH_RST   = 32'd16384;
  localparam logic [7:0]  ITER_CAP_RST      = 8'd64;

endpackage
`default_nettype wire

/* sv/kmd_div.sv */
// Signed-by-unsigned restoring divider, one quotient bit per cycle,
// truncating toward zero. Depends on kmd_pkg.
`default_nettype none
module kmd_div #(
  parameter int NUM_W = 25,
  parameter int DEN_W = 9
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [NUM_W-1:0] dividend,
  input  wire logic [DEN_W-1:0]        divisor,
  output logic                         done,
  output logic signed [NUM_W-1:0]      quotient
);
  import kmd_pkg::*;

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  q_r;
  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic              neg_r;
  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DEN_W:0]    trial;
  logic [NUM_W-1:0]  mag;

  // Magnitude of the dividend; the most negative value maps correctly as unsigned.
  assign mag   = dividend[NUM_W-1] ? NUM_W'(-dividend) : NUM_W'(dividend);
  assign trial = {rem_r, q_r[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r    <= mag;
        rem_r  <= '0;
        den_r  <= divisor;
        neg_r  <= dividend[NUM_W-1];
        busy_r <= 1'b1;
        step_r <= STEP_W'(NUM_W);
      end else if (busy_r) begin
        // One restoring step: shift in the next dividend bit and try a subtract.
        if (trial >= {1'b0, den_r}) begin
          rem_r <= DEN_W'(trial - {1'b0, den_r});
          q_r   <= {q_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= trial[DEN_W-1:0];
          q_r   <= {q_r[NUM_W-2:0], 1'b0};
        end
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed(q_r) : $signed(q_r);

endmodule
`default_nettype wire

/* sv/kmeans_2d_manhattan_core.sv */
// Top level of the 2-D Manhattan-distance k-means core.
// Depends on kmd_pkg and kmd_div.
//
// Points stream in at one transaction per cycle and are kept in an on-chip
// point memory; a point beyond MAX_POINTS is dropped and flagged. The point
// marked final closes the data set: the input then stalls while the core
// seeds k centroids from points 0..k-1 (modulo n) and runs Lloyd
// iterations. Each iteration has an assignment pass, which reads one point
// per memory access and scans the centroids one per cycle, and a mean
// update per non-empty cluster through the bit-serial divider; an empty
// cluster is skipped. Then k centroid records leave at up to one per cycle
// as the output channel allows, and the core loads the next data set. No
// clearing pass follows reset.
`default_nettype none
module kmeans_2d_manhattan_core #(
  parameter int MAX_POINTS   = 256,
  parameter int MAX_CLUSTERS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Point input channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire kmd_pkg::coord_t       in_coord_x,
  input  wire kmd_pkg::coord_t       in_coord_y,
  input  wire logic                  in_final_point,
  // Centroid record channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [3:0]                 out_centroid_index,
  output kmd_pkg::coord_t            out_centroid_x,
  output kmd_pkg::coord_t            out_centroid_y,
  output logic [8:0]                 out_member_count,
  output logic [7:0]                 out_iterations_run,
  output logic                       out_converged,
  output logic                       out_points_dropped,
  output logic                       out_last_record,
  // Configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [3:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import kmd_pkg::*;

  localparam int PW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNTW = $clog2(MAX_POINTS + 1);
  localparam int KW   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int KCW  = $clog2(MAX_CLUSTERS + 1);
  localparam int SUMW = COORD_W + CNTW;

  typedef enum logic [3:0] {
    ST_LOAD, ST_SEED_RD, ST_SEED_WR, ST_ITER, ST_A_RD, ST_A_CMP, ST_A_ACC,
    ST_U_CHK, ST_U_DX, ST_U_DY, ST_U_MX, ST_U_MY, ST_U_MC, ST_U_NEXT, ST_OUT
  } state_t;

  state_t state_r;

  // Configuration registers
  logic [4:0]  cluster_count_r;
  logic [31:0] move_thresh_r;
  logic [7:0]  iter_cap_r;

  // Point memory, {x, y} per entry, one write and one registered read port
  logic [2*COORD_W-1:0] pt_mem [MAX_POINTS];
  logic [2*COORD_W-1:0] pt_q_r;
  logic                 pt_rd_en;
  logic [PW-1:0]        pt_rd_addr;
  logic                 pt_wr_en;
  coord_t               pt_x, pt_y;

  // Per-cluster state
  coord_t                 cen_x_r [MAX_CLUSTERS];
  coord_t                 cen_y_r [MAX_CLUSTERS];
  logic signed [SUMW-1:0] sum_x_r [MAX_CLUSTERS];
  logic signed [SUMW-1:0] sum_y_r [MAX_CLUSTERS];
  logic [CNTW-1:0]        cnt_r   [MAX_CLUSTERS];

  // Run control
  logic [CNTW-1:0] loaded_r;
  logic            ovf_r;
  logic [KCW-1:0]  k_r;
  logic [7:0]      cap_r;
  logic [7:0]      iters_r;
  logic            moved_r;
  logic [PW-1:0]   pi_r;
  logic [PW-1:0]   seed_r;
  logic [KW-1:0]   j_r;
  logic [KW-1:0]   best_j_r;
  logic [17:0]     best_d_r;
  coord_t          ax_r, ay_r;
  logic [33:0]     sqx_r, sqy_r;

  logic            out_valid_r;
  logic            in_take;
  logic            out_load;
  logic            last_j;
  logic            last_pt;
  logic [KW-1:0]   sa;

  logic signed [16:0] dxa, dya;
  logic [16:0]        adx, ady;
  logic [17:0]        man_dist;
  logic signed [16:0] mdx, mdy;
  logic [34:0]        mv_sum;
  logic [KCW-1:0]     k_nxt;
  logic [7:0]         cap_nxt;
  logic [7:0]         iters_nxt;

  logic                   div_start;
  logic                   div_done;
  logic signed [SUMW-1:0] div_num;
  logic signed [SUMW-1:0] div_q;

  assign pready   = 1'b1;
  assign in_stall = (state_r != ST_LOAD);
  assign in_take  = in_valid && !in_stall;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || !out_stall);
  assign last_j   = (KCW'(j_r) + 1'b1) == k_r;
  assign last_pt  = (CNTW'(pi_r) + 1'b1) == loaded_r;
  assign pt_x     = coord_t'(pt_q_r[2*COORD_W-1:COORD_W]);
  assign pt_y     = coord_t'(pt_q_r[COORD_W-1:0]);

  // Configuration writes and reads.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cluster_count_r <= CLUSTER_COUNT_RST;
      move_thresh_r   <= MOVE_THRESH_RST;
      iter_cap_r      <= ITER_CAP_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_CLUSTER_COUNT: cluster_count_r <= pwdata[4:0];
        REG_MOVE_THRESH:   move_thresh_r   <= pwdata;
        REG_ITER_CAP:      iter_cap_r      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CLUSTER_COUNT: prdata = {27'd0, cluster_count_r};
      REG_MOVE_THRESH:   prdata = move_thresh_r;
      REG_ITER_CAP:      prdata = {24'd0, iter_cap_r};
      default:           prdata = '0;
    endcase
  end

  // Effective cluster count and iteration cap for a run.
  always_comb begin
    if (cluster_count_r == 5'd0) begin
      k_nxt = KCW'(1);
    end else if (32'(cluster_count_r) > 32'(MAX_CLUSTERS)) begin
      k_nxt = KCW'(MAX_CLUSTERS);
    end else begin
      k_nxt = KCW'(cluster_count_r);
    end
    cap_nxt   = (iter_cap_r == 8'd0) ? 8'd1 : iter_cap_r;
    iters_nxt = iters_r + 8'd1;
  end

  // Point memory ports.
  assign pt_wr_en   = in_take && (loaded_r != CNTW'(MAX_POINTS));
  assign pt_rd_en   = (state_r == ST_SEED_RD) || (state_r == ST_A_RD);
  assign pt_rd_addr = (state_r == ST_SEED_RD) ? seed_r : pi_r;

  always_ff @(posedge clk) begin
    if (pt_wr_en) begin
      pt_mem[loaded_r[PW-1:0]] <= {in_coord_x, in_coord_y};
    end
    if (pt_rd_en) begin
      pt_q_r <= pt_mem[pt_rd_addr];
    end
  end

  // Manhattan distance from the current point to centroid j.
  always_comb begin
    dxa      = 17'(cen_x_r[j_r]) - 17'(pt_x);
    dya      = 17'(cen_y_r[j_r]) - 17'(pt_y);
    adx      = dxa[16] ? 17'(-dxa) : 17'(dxa);
    ady      = dya[16] ? 17'(-dya) : 17'(dya);
    man_dist = 18'(adx) + 18'(ady);
  end

  // Centroid move, squared, from the old centroid to the new mean.
  assign mdx    = 17'(cen_x_r[j_r]) - 17'(ax_r);
  assign mdy    = 17'(cen_y_r[j_r]) - 17'(ay_r);
  assign mv_sum = 35'(sqx_r) + 35'(sqy_r);

  // One address into the accumulators: the winning cluster or the update index.
  assign sa = (state_r == ST_A_ACC) ? best_j_r : j_r;

  // Divider feed: x mean starts from the check state, y mean when x is done.
  assign div_start = ((state_r == ST_U_CHK) && (cnt_r[sa] != '0)) ||
                     ((state_r == ST_U_DX) && div_done);
  assign div_num   = (state_r == ST_U_CHK) ? sum_x_r[sa] : sum_y_r[sa];

  kmd_div #(
    .NUM_W (SUMW),
    .DEN_W (CNTW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (cnt_r[sa]),
    .done     (div_done),
    .quotient (div_q)
  );

  // Sequencer: load, seed, assign and accumulate, update, emit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      loaded_r    <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      j_r         <= '0;
      pi_r        <= '0;
      seed_r      <= '0;
      moved_r     <= 1'b0;
      iters_r     <= '0;
      k_r         <= KCW'(1);
      cap_r       <= 8'd1;
    end else begin
      if (out_load) begin
        out_valid_r        <= 1'b1;
        out_centroid_index <= 4'(j_r);
        out_centroid_x     <= cen_x_r[j_r];
        out_centroid_y     <= cen_y_r[j_r];
        out_member_count   <= 9'(cnt_r[j_r]);
        out_iterations_run <= iters_r;
        out_converged      <= !moved_r;
        out_points_dropped <= ovf_r;
        out_last_record    <= last_j;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_LOAD: begin
          if (in_take) begin
            if (pt_wr_en) begin
              loaded_r <= loaded_r + 1'b1;
            end else begin
              ovf_r <= 1'b1;
            end
            if (in_final_point) begin
              k_r     <= k_nxt;
              cap_r   <= cap_nxt;
              j_r     <= '0;
              seed_r  <= '0;
              iters_r <= '0;
              state_r <= ST_SEED_RD;
            end
          end
        end
        ST_SEED_RD: begin
          state_r <= ST_SEED_WR;
        end
        ST_SEED_WR: begin
          // Centroid j takes point j modulo n.
          cen_x_r[j_r] <= pt_x;
          cen_y_r[j_r] <= pt_y;
          seed_r <= ((CNTW'(seed_r) + 1'b1) == loaded_r) ? '0 : seed_r + 1'b1;
          if (last_j) begin
            state_r <= ST_ITER;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= ST_SEED_RD;
          end
        end
        ST_ITER: begin
          for (int c = 0; c < MAX_CLUSTERS; c++) begin
            sum_x_r[c] <= '0;
            sum_y_r[c] <= '0;
            cnt_r[c]   <= '0;
          end
          moved_r <= 1'b0;
          pi_r    <= '0;
          state_r <= ST_A_RD;
        end
        ST_A_RD: begin
          j_r     <= '0;
          state_r <= ST_A_CMP;
        end
        ST_A_CMP: begin
          // Strictly smaller wins, so the lowest index keeps a tie.
          if (j_r == '0 || man_dist < best_d_r) begin
            best_d_r <= man_dist;
            best_j_r <= j_r;
          end
          if (last_j) begin
            state_r <= ST_A_ACC;
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        ST_A_ACC: begin
          sum_x_r[sa] <= sum_x_r[sa] + SUMW'(pt_x);
          sum_y_r[sa] <= sum_y_r[sa] + SUMW'(pt_y);
          cnt_r[sa]   <= cnt_r[sa] + 1'b1;
          if (last_pt) begin
            j_r     <= '0;
            state_r <= ST_U_CHK;
          end else begin
            pi_r    <= pi_r + 1'b1;
            state_r <= ST_A_RD;
          end
        end
        ST_U_CHK: begin
          // An empty cluster keeps its centroid.
          state_r <= (cnt_r[sa] != '0) ? ST_U_DX : ST_U_NEXT;
        end
        ST_U_DX: begin
          if (div_done) begin
            ax_r    <= coord_t'(div_q[COORD_W-1:0]);
            state_r <= ST_U_DY;
          end
        end
        ST_U_DY: begin
          if (div_done) begin
            ay_r    <= coord_t'(div_q[COORD_W-1:0]);
            state_r <= ST_U_MX;
          end
        end
        ST_U_MX: begin
          sqx_r   <= 34'(mdx) * 34'(mdx);
          state_r <= ST_U_MY;
        end
        ST_U_MY: begin
          sqy_r   <= 34'(mdy) * 34'(mdy);
          state_r <= ST_U_MC;
        end
        ST_U_MC: begin
          if (mv_sum > 35'(move_thresh_r)) begin
            moved_r <= 1'b1;
          end
          cen_x_r[j_r] <= ax_r;
          cen_y_r[j_r] <= ay_r;
          state_r      <= ST_U_NEXT;
        end
        ST_U_NEXT: begin
          if (last_j) begin
            iters_r <= iters_nxt;
            j_r     <= '0;
            state_r <= (moved_r && iters_nxt < cap_r) ? ST_ITER : ST_OUT;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= ST_U_CHK;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            if (last_j) begin
              loaded_r <= '0;
              ovf_r    <= 1'b0;
              state_r  <= ST_LOAD;
            end else begin
              j_r <= j_r + 1'b1;
            end
          end
        end
        default: begin
          state_r <= ST_LOAD;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire
